// ----- src/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types and constants of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // command codes
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR      = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] item_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] popped_data;
      logic [63:0] front_data;
      logic [63:0] back_data;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef enum logic [0:0] {
      CTL_IDLE,
      CTL_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic exec;
      logic load;
   } ctl_cmd_type;

endpackage

// ----- src/rbd_ram.sv -----
// ----------------------------------------------------------------------------
// rbd_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- src/rbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbd_ctrl
// sequencer: accepts a word, waits for ring reads, hands off the result
// ----------------------------------------------------------------------------
module rbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rbd_pkg::ctl_cmd_type cmd
);

   rbd_pkg::ctl_state_type state_ff;
   rbd_pkg::ctl_state_type state_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbd_pkg::CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.exec     = 1'b0;
      cmd.load     = 1'b0;
      case (state_ff)
         rbd_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = rbd_pkg::CTL_FINISH;
            end
         end
         rbd_pkg::CTL_FINISH: begin
            if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rbd_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = rbd_pkg::CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/rbd_datapath.sv -----
// ----------------------------------------------------------------------------
// rbd_datapath
// ring indices, entry count, end word cache and result register
// ----------------------------------------------------------------------------
module rbd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rbd_pkg::ctl_cmd_type cmd,
   input  rbd_pkg::req_type     req_data,
   output rbd_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = rbd_pkg::IDX_W;
   localparam int CNT_W = rbd_pkg::CNT_W;
   localparam int DW    = rbd_pkg::DATA_WIDTH;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(rbd_pkg::DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(rbd_pkg::DEPTH - 1) : idx - IDX_W'(1);
   endfunction

   logic [IDX_W-1:0] front_idx_ff, front_idx_in;
   logic [IDX_W-1:0] back_idx_ff, back_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       status_ff, status_in;
   logic [DW-1:0]    popped_ff, popped_in;
   logic [DW-1:0]    front_word_ff, front_word_in;
   logic [DW-1:0]    back_word_ff, back_word_in;
   logic             byp_front_ff, byp_back_ff;
   logic [DW-1:0]    byp_word_ff;
   rbd_pkg::rsp_type rsp_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [DW-1:0]    wr_data;
   logic [IDX_W-1:0] rd_addr_front;
   logic [IDX_W-1:0] rd_addr_back;
   logic [DW-1:0]    rd_front;
   logic [DW-1:0]    rd_back;
   logic             full;
   logic             empty;

   assign full    = (count_ff == CNT_W'(rbd_pkg::DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_data = req_data.item_data[DW-1:0];

   // command decode, only meaningful while exec is high
   always_comb begin
      front_idx_in = front_idx_ff;
      back_idx_in  = back_idx_ff;
      count_in     = count_ff;
      status_in    = rbd_pkg::STATUS_OK;
      popped_in    = '0;
      wr_en        = 1'b0;
      wr_addr      = front_idx_ff;
      case (req_data.func)
         rbd_pkg::FUNC_PUSH_FRONT: begin
            if (full) begin
               status_in = rbd_pkg::STATUS_FULL;
            end else begin
               front_idx_in = idx_dec(front_idx_ff);
               count_in     = count_ff + CNT_W'(1);
               wr_en        = cmd.exec;
               wr_addr      = front_idx_in;
            end
         end
         rbd_pkg::FUNC_PUSH_BACK: begin
            if (full) begin
               status_in = rbd_pkg::STATUS_FULL;
            end else begin
               back_idx_in = idx_inc(back_idx_ff);
               count_in    = count_ff + CNT_W'(1);
               wr_en       = cmd.exec;
               wr_addr     = back_idx_in;
            end
         end
         rbd_pkg::FUNC_POP_FRONT: begin
            if (empty) begin
               status_in = rbd_pkg::STATUS_EMPTY;
            end else begin
               popped_in    = front_word_ff;
               front_idx_in = idx_inc(front_idx_ff);
               count_in     = count_ff - CNT_W'(1);
            end
         end
         rbd_pkg::FUNC_POP_BACK: begin
            if (empty) begin
               status_in = rbd_pkg::STATUS_EMPTY;
            end else begin
               popped_in   = back_word_ff;
               back_idx_in = idx_dec(back_idx_ff);
               count_in    = count_ff - CNT_W'(1);
            end
         end
         rbd_pkg::FUNC_CLEAR: begin
            front_idx_in = '0;
            back_idx_in  = IDX_W'(rbd_pkg::DEPTH - 1);
            count_in     = '0;
         end
         default: begin
         end
      endcase
   end

   // new ends on the accept cycle, then the held ends while a response waits
   assign rd_addr_front = cmd.exec ? front_idx_in : front_idx_ff;
   assign rd_addr_back  = cmd.exec ? back_idx_in : back_idx_ff;

   rbd_ram #(
      .WIDTH (DW),
      .DEPTH (rbd_pkg::DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_front),
      .rd_addr_b (rd_addr_back),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   // new end words, with bypass of a word written in the same cycle
   always_comb begin
      if (count_ff == '0) begin
         front_word_in = '0;
         back_word_in  = '0;
      end else begin
         front_word_in = byp_front_ff ? byp_word_ff : rd_front;
         back_word_in  = byp_back_ff ? byp_word_ff : rd_back;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         back_idx_ff  <= IDX_W'(rbd_pkg::DEPTH - 1);
         count_ff     <= '0;
      end else if (cmd.exec) begin
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         byp_front_ff <= wr_en && (wr_addr == front_idx_in);
         byp_back_ff  <= wr_en && (wr_addr == back_idx_in);
         byp_word_ff  <= wr_data;
      end
      if (cmd.load) begin
         front_word_ff        <= front_word_in;
         back_word_ff         <= back_word_in;
         rsp_ff.status        <= status_ff;
         rsp_ff.popped_data   <= 64'(popped_ff);
         rsp_ff.front_data    <= 64'(front_word_in);
         rsp_ff.back_data     <= 64'(back_word_in);
         rsp_ff.entry_count   <= 7'(count_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/ring_buffer_deque_unit.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit
// bounded double-ended queue of data words held in a ring ram
// ----------------------------------------------------------------------------
// Each request word carries one command: push front, push back, pop front,
// pop back or clear. Every response word reports a status (ok, empty error
// on a pop, full error on a push), the popped word, the front and back words
// after the command (zero when empty) and the entry count. An item passes an
// accept state and a finish state: the accept cycle updates the ring indices,
// writes the ram and issues reads of both new end words; the finish state,
// once the response side is free, takes the registered ram read data into the
// response register, which frees the request side: the next word is accepted
// while a response still waits, and a response not taken holds the following
// item in its finish state. No clearing pass is needed after reset.
module ring_buffer_deque_unit (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  rbd_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbd_pkg::rsp_type rsp_data
);

   // command lines from the sequencer to the datapath
   rbd_pkg::ctl_cmd_type cmd;

   // sequencer: handshakes and the two-step item flow
   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: ring ram, indices, count, end word cache, response register
   rbd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ----- verif/tb_ring_buffer_deque_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque_unit
// self-checking testbench of the ring buffer deque
// ----------------------------------------------------------------------------
// Drives command words into the request channel and follows each accepted
// word with an in-bench deque model that predicts the status, popped word,
// end words and entry count. A checker process compares every response word
// with the oldest prediction. Directed tests cover empty pops, extreme data,
// unused codes and clear; a long response hold-off stalls the input while
// pushes wait, and the pushes then fill the queue until it reports full errors;
// random fill, drain and mixed bursts then run under three idle patterns.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque_unit;

   // highest command code; codes above clear do nothing
   localparam logic [2:0]  FUNC_LAST_CODE = 3'd7;
   localparam logic [63:0] WORD_MASK      = {64{1'b1}} >> (64 - rbd_pkg::DATA_WIDTH);
   localparam int          CNT_W          = rbd_pkg::CNT_W;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rbd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rbd_pkg::rsp_type rsp_data;

   // idle percentages of the two sides and the receiver hold-off
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_off_cycles = 0;
   int error_count     = 0;

   // deque model state
   logic [63:0] ring_model [rbd_pkg::DEPTH];
   int          model_front = 0;
   int          model_count = 0;

   // predictions waiting for their response word
   rbd_pkg::rsp_type expected_deque_rsps [$];

   ring_buffer_deque_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // apply one command to the model and build the response it should give
   function automatic rbd_pkg::rsp_type predict_deque_op(input rbd_pkg::req_type cmd);
      rbd_pkg::rsp_type res;
      logic [63:0]      din;
      res = '0;
      res.status = rbd_pkg::STATUS_OK;
      din = cmd.item_data & WORD_MASK;
      case (cmd.func)
         rbd_pkg::FUNC_PUSH_FRONT, rbd_pkg::FUNC_PUSH_BACK: begin
            if (model_count >= rbd_pkg::DEPTH) begin
               res.status = rbd_pkg::STATUS_FULL;
            end else if (cmd.func == rbd_pkg::FUNC_PUSH_FRONT) begin
               // front moves down one slot, wrapping below zero
               model_front = (model_front + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH;
               ring_model[model_front] = din;
               model_count++;
            end else begin
               ring_model[(model_front + model_count) % rbd_pkg::DEPTH] = din;
               model_count++;
            end
         end
         rbd_pkg::FUNC_POP_FRONT: begin
            if (model_count == 0) begin
               res.status = rbd_pkg::STATUS_EMPTY;
            end else begin
               res.popped_data = ring_model[model_front];
               model_front = (model_front + 1) % rbd_pkg::DEPTH;
               model_count--;
            end
         end
         rbd_pkg::FUNC_POP_BACK: begin
            if (model_count == 0) begin
               res.status = rbd_pkg::STATUS_EMPTY;
            end else begin
               res.popped_data =
                  ring_model[(model_front + model_count - 1) % rbd_pkg::DEPTH];
               model_count--;
            end
         end
         rbd_pkg::FUNC_CLEAR: begin
            model_count = 0;
            model_front = 0;
         end
         default: begin
         end
      endcase
      // end words read only from held entries, zero when empty
      if (model_count != 0) begin
         res.front_data = ring_model[model_front];
         res.back_data  = ring_model[(model_front + model_count - 1) % rbd_pkg::DEPTH];
      end
      res.entry_count = CNT_W'(model_count);
      return res;
   endfunction

   // random data word with the extremes mixed in
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one request word and wait until it is accepted
   task automatic send_word(input logic [2:0] func, input logic [63:0] data);
      rbd_pkg::req_type cmd;
      cmd.func      = func;
      cmd.item_data = data;
      // optional idle gap with valid low
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      expected_deque_rsps.push_back(predict_deque_op(cmd));
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_rsp_word(input rbd_pkg::rsp_type got);
      rbd_pkg::rsp_type want;
      if (expected_deque_rsps.size() == 0) begin
         error_count++;
         $display("%0t: unexpected response word, expected none, actual %h", $time, got);
         return;
      end
      want = expected_deque_rsps.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("popped_data", want.popped_data, got.popped_data);
      compare_field("front_data", want.front_data, got.front_data);
      compare_field("back_data", want.back_data, got.back_data);
      compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
   endtask

   // response side: check each accepted word, then pick the next ready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_rsp_word(rsp_data);
         if (hold_off_cycles > 0) begin
            // long hold-off so the block stalls its input
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // pops on an empty queue report the empty error
   task automatic test_empty_pops();
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
      send_word(rbd_pkg::FUNC_POP_BACK, rand_word());
   endtask

   // extreme data at both ends, then pops from both ends down to empty and one beyond
   task automatic test_end_words();
      send_word(rbd_pkg::FUNC_PUSH_FRONT, '1);
      send_word(rbd_pkg::FUNC_PUSH_BACK, '0);
      send_word(rbd_pkg::FUNC_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(rbd_pkg::FUNC_PUSH_BACK, 64'h5555_5555_5555_5555);
      send_word(rbd_pkg::FUNC_PUSH_BACK, 64'h8000_0000_0000_0001);
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
      send_word(rbd_pkg::FUNC_POP_BACK, rand_word());
      send_word(rbd_pkg::FUNC_POP_BACK, rand_word());
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
      send_word(rbd_pkg::FUNC_POP_BACK, rand_word());
   endtask

   // unused codes leave the queue alone
   task automatic test_unused_codes();
      logic [2:0] code;
      send_word(rbd_pkg::FUNC_PUSH_BACK, rand_word());
      for (code = rbd_pkg::FUNC_CLEAR + 3'd1; code != 3'd0; code++)
         send_word(code, rand_word());
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
   endtask

   // clear empties the queue, stale entries stay unreachable
   task automatic test_clear();
      repeat (3) send_word(rbd_pkg::FUNC_PUSH_FRONT, rand_word());
      send_word(rbd_pkg::FUNC_CLEAR, rand_word());
      send_word(rbd_pkg::FUNC_POP_BACK, rand_word());
      send_word(rbd_pkg::FUNC_CLEAR, rand_word());
      send_word(rbd_pkg::FUNC_PUSH_BACK, rand_word());
      send_word(rbd_pkg::FUNC_POP_FRONT, rand_word());
   endtask

   // receiver holds off while pushes keep coming; queue goes full, then drains
   task automatic test_backpressure_fill();
      send_word(rbd_pkg::FUNC_CLEAR, rand_word());
      hold_off_cycles = 600;
      repeat (rbd_pkg::DEPTH + 8)
         send_word($urandom_range(0, 1) ? rbd_pkg::FUNC_PUSH_BACK
                                         : rbd_pkg::FUNC_PUSH_FRONT, rand_word());
      repeat (rbd_pkg::DEPTH + 6)
         send_word($urandom_range(0, 1) ? rbd_pkg::FUNC_POP_BACK
                                         : rbd_pkg::FUNC_POP_FRONT, rand_word());
   endtask

   // random bursts that lean toward filling, draining or neither
   task automatic test_random_traffic(input int n_items);
      int         sent;
      int         burst_left;
      int         push_pct;
      int         roll;
      logic [2:0] func;
      sent = 0;
      burst_left = 0;
      push_pct = 50;
      while (sent < n_items) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
               0:       push_pct = 90;
               1:       push_pct = 12;
               default: push_pct = 50;
            endcase
         end
         roll = $urandom_range(0, 199);
         if (roll == 0)
            func = rbd_pkg::FUNC_CLEAR;
         else if (roll < 5)
            func = 3'($urandom_range(rbd_pkg::FUNC_CLEAR + 1, FUNC_LAST_CODE));
         else if ($urandom_range(0, 99) < push_pct)
            func = $urandom_range(0, 1) ? rbd_pkg::FUNC_PUSH_BACK
                                        : rbd_pkg::FUNC_PUSH_FRONT;
         else
            func = $urandom_range(0, 1) ? rbd_pkg::FUNC_POP_BACK
                                        : rbd_pkg::FUNC_POP_FRONT;
         send_word(func, rand_word());
         burst_left--;
         sent++;
      end
   endtask

   // stop offering and let every response word come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_deque_rsps.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      reset     <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 23;
      recv_idle_pct = 79;
      test_empty_pops();
      test_end_words();
      test_unused_codes();
      test_clear();
      test_random_traffic(300);

      // the other way round
      send_idle_pct = 79;
      recv_idle_pct = 23;
      test_backpressure_fill();
      test_random_traffic(300);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(300);

      wait_for_drain();
      if (expected_deque_rsps.size() != 0)
         error_count++;
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
